// File: sv/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CEM_ASSERT_IMPL(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion violated");

`define CEM_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion violated");

`endif

// File: sv/cem_pkg.sv
package cem_pkg;

   localparam int FRAC_BITS_DEF  = 16;
   localparam int WORD_WIDTH_DEF = 32;
   localparam int FIELD_W        = 32;
   localparam int LIMB_W         = 32;
   localparam int LIMB_IDX_W     = 3;
   localparam int NPARAM         = 20;
   localparam int IDX_W          = 5;
   localparam int STEPS          = 24;
   localparam int STEP_W         = 5;

   localparam logic [IDX_W-1:0] MASS_A_IDX = 5'd0;
   localparam logic [IDX_W-1:0] INER_A_IDX = 5'd1;
   localparam logic [IDX_W-1:0] MASS_B_IDX = 5'd10;
   localparam logic [IDX_W-1:0] INER_B_IDX = 5'd11;

   localparam int REQ_TDATA_W = 328;
   localparam int OFS_PIDX    = 0;
   localparam int OFS_PVAL    = 5;
   localparam int OFS_ARM_A   = 37;
   localparam int OFS_ARM_B   = 133;
   localparam int OFS_DIR     = 229;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_EVAL  = 1'b1;

   typedef enum logic [3:0] {
      X_R0, X_R1, X_R2, X_C0, X_C1, X_C2, X_T0, X_T1, X_T2, X_U0, X_U1, X_U2
   } xsel_type;

   typedef enum logic [3:0] {
      W_N0, W_N1, W_N2, W_R0, W_R1, W_R2,
      W_I0, W_I1, W_I2, W_I3, W_I4, W_I5, W_I6, W_I7, W_I8
   } wsel_type;

   typedef enum logic [3:0] {
      D_C0, D_C1, D_C2, D_T0, D_T1, D_T2, D_U0, D_U1, D_U2, D_K
   } dsel_type;

   typedef struct packed {
      xsel_type x;
      wsel_type w;
      logic     sub;
      dsel_type d;
      logic     last;
   } ustep_type;

   typedef struct packed {
      logic                  write;
      logic                  capture;
      logic                  init;
      logic                  issue;
      ustep_type             op;
      logic                  body;
      logic [LIMB_IDX_W-1:0] limb;
      logic                  last_limb;
      logic                  rnd;
      logic                  sat;
   } cmd_type;

   typedef struct packed {
      logic rsp_busy;
   } sts_type;

   function automatic ustep_type ustep(logic [STEP_W-1:0] idx);
      ustep_type s;
      case (idx)
         5'd0:    s = '{X_R1, W_N2, 1'b0, D_C0, 1'b0};
         5'd1:    s = '{X_R2, W_N1, 1'b1, D_C0, 1'b1};
         5'd2:    s = '{X_R2, W_N0, 1'b0, D_C1, 1'b0};
         5'd3:    s = '{X_R0, W_N2, 1'b1, D_C1, 1'b1};
         5'd4:    s = '{X_R0, W_N1, 1'b0, D_C2, 1'b0};
         5'd5:    s = '{X_R1, W_N0, 1'b1, D_C2, 1'b1};
         5'd6:    s = '{X_C0, W_I0, 1'b0, D_T0, 1'b0};
         5'd7:    s = '{X_C1, W_I3, 1'b0, D_T0, 1'b0};
         5'd8:    s = '{X_C2, W_I6, 1'b0, D_T0, 1'b1};
         5'd9:    s = '{X_C0, W_I1, 1'b0, D_T1, 1'b0};
         5'd10:   s = '{X_C1, W_I4, 1'b0, D_T1, 1'b0};
         5'd11:   s = '{X_C2, W_I7, 1'b0, D_T1, 1'b1};
         5'd12:   s = '{X_C0, W_I2, 1'b0, D_T2, 1'b0};
         5'd13:   s = '{X_C1, W_I5, 1'b0, D_T2, 1'b0};
         5'd14:   s = '{X_C2, W_I8, 1'b0, D_T2, 1'b1};
         5'd15:   s = '{X_T1, W_R2, 1'b0, D_U0, 1'b0};
         5'd16:   s = '{X_T2, W_R1, 1'b1, D_U0, 1'b1};
         5'd17:   s = '{X_T2, W_R0, 1'b0, D_U1, 1'b0};
         5'd18:   s = '{X_T0, W_R2, 1'b1, D_U1, 1'b1};
         5'd19:   s = '{X_T0, W_R1, 1'b0, D_U2, 1'b0};
         5'd20:   s = '{X_T1, W_R0, 1'b1, D_U2, 1'b1};
         5'd21:   s = '{X_U0, W_N0, 1'b0, D_K, 1'b1};
         5'd22:   s = '{X_U1, W_N1, 1'b0, D_K, 1'b1};
         5'd23:   s = '{X_U2, W_N2, 1'b0, D_K, 1'b1};
         default: s = '{X_R0, W_N0, 1'b0, D_K, 1'b1};
      endcase
      return s;
   endfunction

endpackage

// File: sv/cem_ctrl.sv
`include "assert_macros.svh"

module cem_ctrl #(
   parameter int WORD_WIDTH = cem_pkg::WORD_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tuser,
   output logic             req_tready,
   input  cem_pkg::sts_type sts,
   output cem_pkg::cmd_type cmd
);

   localparam int LW  = cem_pkg::LIMB_W;
   localparam int L_R = (WORD_WIDTH + LW - 1) / LW;
   localparam int L_C = (2 * WORD_WIDTH + 2 + LW - 1) / LW;
   localparam int L_T = (3 * WORD_WIDTH + 4 + LW - 1) / LW;
   localparam int L_U = (4 * WORD_WIDTH + 6 + LW - 1) / LW;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_INIT  = 6'b000010,
      S_RUN   = 6'b000100,
      S_DRAIN = 6'b001000,
      S_RND   = 6'b010000,
      S_SAT   = 6'b100000
   } state_type;

   state_type                             state_ff, state_in;
   logic [cem_pkg::STEP_W-1:0]            step_ff, step_in;
   logic [cem_pkg::LIMB_IDX_W-1:0]        limb_ff, limb_in;
   logic                                  body_ff, body_in;
   cem_pkg::ustep_type                    op;
   logic [cem_pkg::LIMB_IDX_W-1:0]        limb_top;

   always_comb begin
      op = cem_pkg::ustep(step_ff);
      case (op.x)
         cem_pkg::X_R0, cem_pkg::X_R1, cem_pkg::X_R2: limb_top = cem_pkg::LIMB_IDX_W'(L_R - 1);
         cem_pkg::X_C0, cem_pkg::X_C1, cem_pkg::X_C2: limb_top = cem_pkg::LIMB_IDX_W'(L_C - 1);
         cem_pkg::X_T0, cem_pkg::X_T1, cem_pkg::X_T2: limb_top = cem_pkg::LIMB_IDX_W'(L_T - 1);
         cem_pkg::X_U0, cem_pkg::X_U1, cem_pkg::X_U2: limb_top = cem_pkg::LIMB_IDX_W'(L_U - 1);
         default:                                     limb_top = cem_pkg::LIMB_IDX_W'(L_R - 1);
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      limb_in       = limb_ff;
      body_in       = body_ff;
      cmd           = '0;
      cmd.op        = op;
      cmd.body      = body_ff;
      cmd.limb      = limb_ff;
      cmd.last_limb = (limb_ff == limb_top);
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == cem_pkg::MODE_WRITE) begin
                  cmd.write = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  state_in    = S_INIT;
               end
            end
         end
         S_INIT: begin
            cmd.init = 1'b1;
            step_in  = '0;
            limb_in  = '0;
            body_in  = 1'b0;
            state_in = S_RUN;
         end
         S_RUN: begin
            cmd.issue = 1'b1;
            if (limb_ff != limb_top) begin
               limb_in = limb_ff + 1'b1;
            end else begin
               limb_in = '0;
               if (step_ff == cem_pkg::STEP_W'(cem_pkg::STEPS - 1)) begin
                  step_in = '0;
                  if (body_ff) begin
                     state_in = S_DRAIN;
                  end else begin
                     body_in = 1'b1;
                  end
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         S_DRAIN: begin
            state_in = S_RND;
         end
         S_RND: begin
            cmd.rnd  = 1'b1;
            state_in = S_SAT;
         end
         S_SAT: begin
            if (!sts.rsp_busy) begin
               cmd.sat  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         limb_ff  <= '0;
         body_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         limb_ff  <= limb_in;
         body_ff  <= body_in;
      end
   end

   `CEM_ASSERT_IMPL(a_sat_slot_free, clock, reset, cmd.sat, !sts.rsp_busy)
   `CEM_ASSERT_IMPL(a_step_range, clock, reset, state_ff == S_RUN, step_ff < cem_pkg::STEP_W'(cem_pkg::STEPS))
   `CEM_ASSERT_IMPL(a_limb_range, clock, reset, state_ff == S_RUN, limb_ff <= limb_top)
   `CEM_ASSERT_NEXT(a_run_to_drain, clock, reset, state_ff == S_RUN && body_ff && cmd.last_limb && step_ff == cem_pkg::STEP_W'(cem_pkg::STEPS - 1), state_ff == S_DRAIN)

endmodule

// File: sv/cem_dpath.sv
module cem_dpath #(
   parameter int FRAC_BITS  = cem_pkg::FRAC_BITS_DEF,
   parameter int WORD_WIDTH = cem_pkg::WORD_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  cem_pkg::cmd_type                cmd,
   output cem_pkg::sts_type                sts,
   input  logic [cem_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,
   output logic                            rsp_tuser
);

   localparam int W     = WORD_WIDTH;
   localparam int LW    = cem_pkg::LIMB_W;
   localparam int L_U   = (4 * W + 6 + LW - 1) / LW;
   localparam int XW    = L_U * LW;
   localparam int PP_W  = LW + 1 + W;
   localparam int A1    = 5 * W + 8;
   localparam int A2    = 4 * FRAC_BITS + W + 4;
   localparam int A3    = XW + W + 2;
   localparam int A12   = (A1 > A2) ? A1 : A2;
   localparam int ACC_W = (A12 > A3) ? A12 : A3;
   localparam int SH    = 4 * FRAC_BITS;

   localparam logic signed [ACC_W-1:0] MAXV = {{(ACC_W - W + 1){1'b0}}, {(W - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] MINV = {{(ACC_W - W + 1){1'b1}}, {(W - 1){1'b0}}};
   localparam logic signed [ACC_W-1:0] HALF = {{(ACC_W - 1){1'b0}}, 1'b1} << (SH - 1);

   function automatic logic signed [W-1:0] to_word(logic [cem_pkg::FIELD_W-1:0] f);
      logic [63:0] z;
      z = {32'b0, f};
      return z[W-1:0];
   endfunction

   logic signed [W-1:0]      store_ff [cem_pkg::NPARAM];
   logic signed [W-1:0]      ra_ff [3];
   logic signed [W-1:0]      rb_ff [3];
   logic signed [W-1:0]      n_ff [3];
   logic signed [XW-1:0]     c_ff [3];
   logic signed [XW-1:0]     t_ff [3];
   logic signed [XW-1:0]     u_ff [3];
   logic signed [ACC_W-1:0]  tacc_ff, kacc_ff, q_ff;
   logic signed [PP_W-1:0]   pp_ff, pp_in;
   logic                     pv_ff;
   logic [cem_pkg::LIMB_IDX_W-1:0] sh_ff;
   logic                     sub_ff, st_ff;
   cem_pkg::dsel_type        dst_ff;
   logic                     rsp_valid_ff;
   logic [31:0]              rsp_data_ff;
   logic                     rsp_sat_ff;

   logic [cem_pkg::IDX_W-1:0] pidx, ibase, widx;
   logic signed [W-1:0]      r_cur [3];
   logic signed [XW-1:0]     x_val;
   logic signed [W-1:0]      w_val;
   logic [LW-1:0]            limb_bits;
   logic signed [LW:0]       x_limb;
   logic signed [ACC_W-1:0]  pp_ext, pp_sh, adj, tsum, msum, rsum, sat_val;
   logic [63:0]              k_wide;

   assign pidx  = req_tdata[cem_pkg::OFS_PIDX +: cem_pkg::IDX_W];
   assign ibase = cmd.body ? cem_pkg::INER_B_IDX : cem_pkg::INER_A_IDX;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         r_cur[i] = cmd.body ? rb_ff[i] : ra_ff[i];
      end
      case (cmd.op.x)
         cem_pkg::X_R0: x_val = XW'(r_cur[0]);
         cem_pkg::X_R1: x_val = XW'(r_cur[1]);
         cem_pkg::X_R2: x_val = XW'(r_cur[2]);
         cem_pkg::X_C0: x_val = c_ff[0];
         cem_pkg::X_C1: x_val = c_ff[1];
         cem_pkg::X_C2: x_val = c_ff[2];
         cem_pkg::X_T0: x_val = t_ff[0];
         cem_pkg::X_T1: x_val = t_ff[1];
         cem_pkg::X_T2: x_val = t_ff[2];
         cem_pkg::X_U0: x_val = u_ff[0];
         cem_pkg::X_U1: x_val = u_ff[1];
         cem_pkg::X_U2: x_val = u_ff[2];
         default:       x_val = '0;
      endcase
      widx = ibase;
      case (cmd.op.w)
         cem_pkg::W_I0: widx = ibase;
         cem_pkg::W_I1: widx = ibase + 5'd1;
         cem_pkg::W_I2: widx = ibase + 5'd2;
         cem_pkg::W_I3: widx = ibase + 5'd3;
         cem_pkg::W_I4: widx = ibase + 5'd4;
         cem_pkg::W_I5: widx = ibase + 5'd5;
         cem_pkg::W_I6: widx = ibase + 5'd6;
         cem_pkg::W_I7: widx = ibase + 5'd7;
         cem_pkg::W_I8: widx = ibase + 5'd8;
         default:       widx = ibase;
      endcase
      case (cmd.op.w)
         cem_pkg::W_N0: w_val = n_ff[0];
         cem_pkg::W_N1: w_val = n_ff[1];
         cem_pkg::W_N2: w_val = n_ff[2];
         cem_pkg::W_R0: w_val = r_cur[0];
         cem_pkg::W_R1: w_val = r_cur[1];
         cem_pkg::W_R2: w_val = r_cur[2];
         default:       w_val = store_ff[widx];
      endcase
      limb_bits = x_val[cmd.limb * LW +: LW];
      x_limb    = {cmd.last_limb & limb_bits[LW-1], limb_bits};
      pp_in     = x_limb * w_val;
   end

   always_comb begin
      pp_ext  = ACC_W'(pp_ff);
      pp_sh   = pp_ext <<< (sh_ff * LW);
      adj     = sub_ff ? -pp_sh : pp_sh;
      tsum    = tacc_ff + adj;
      msum    = ACC_W'(store_ff[cem_pkg::MASS_A_IDX]) + ACC_W'(store_ff[cem_pkg::MASS_B_IDX]);
      rsum    = (kacc_ff + HALF) >>> SH;
      sat_val = q_ff;
      if (q_ff > MAXV) begin
         sat_val = MAXV;
      end else if (q_ff < MINV) begin
         sat_val = MINV;
      end
      k_wide = 64'(sat_val[W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cem_pkg::NPARAM; i++) begin
            store_ff[i] <= '0;
         end
      end else if (cmd.write && pidx < cem_pkg::IDX_W'(cem_pkg::NPARAM)) begin
         store_ff[pidx] <= to_word(req_tdata[cem_pkg::OFS_PVAL +: cem_pkg::FIELD_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         for (int i = 0; i < 3; i++) begin
            ra_ff[i] <= to_word(req_tdata[cem_pkg::OFS_ARM_A + i * 32 +: cem_pkg::FIELD_W]);
            rb_ff[i] <= to_word(req_tdata[cem_pkg::OFS_ARM_B + i * 32 +: cem_pkg::FIELD_W]);
            n_ff[i]  <= to_word(req_tdata[cem_pkg::OFS_DIR + i * 32 +: cem_pkg::FIELD_W]);
         end
      end
   end

   always_ff @(posedge clock) begin
      pp_ff  <= pp_in;
      sh_ff  <= cmd.limb;
      sub_ff <= cmd.op.sub;
      dst_ff <= cmd.op.d;
      st_ff  <= cmd.op.last && cmd.last_limb;
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         kacc_ff <= msum <<< SH;
         tacc_ff <= '0;
      end else if (pv_ff) begin
         if (dst_ff == cem_pkg::D_K) begin
            kacc_ff <= kacc_ff + adj;
         end else if (st_ff) begin
            tacc_ff <= '0;
            case (dst_ff)
               cem_pkg::D_C0: c_ff[0] <= tsum[XW-1:0];
               cem_pkg::D_C1: c_ff[1] <= tsum[XW-1:0];
               cem_pkg::D_C2: c_ff[2] <= tsum[XW-1:0];
               cem_pkg::D_T0: t_ff[0] <= tsum[XW-1:0];
               cem_pkg::D_T1: t_ff[1] <= tsum[XW-1:0];
               cem_pkg::D_T2: t_ff[2] <= tsum[XW-1:0];
               cem_pkg::D_U0: u_ff[0] <= tsum[XW-1:0];
               cem_pkg::D_U1: u_ff[1] <= tsum[XW-1:0];
               cem_pkg::D_U2: u_ff[2] <= tsum[XW-1:0];
               default: ;
            endcase
         end else begin
            tacc_ff <= tsum;
         end
      end
      if (cmd.rnd) begin
         q_ff <= rsum;
      end
      if (cmd.sat) begin
         rsp_data_ff <= k_wide[31:0];
         rsp_sat_ff  <= (q_ff > MAXV) || (q_ff < MINV);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.sat) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign sts.rsp_busy = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser    = rsp_sat_ff;

endmodule

// File: sv/contact_effective_mass_unit.sv
// write item: taken while idle, stored in the parameter store, no result
// evaluate item: each microstep is issued limb by limb, for body a and then body b, limbs of 32 bits,
// then rounded and saturated; all products come from the one shared 33 x W multiplier
// one evaluate at a time; the next item is taken while a result waits in the output register
// reset: parameter store cleared to zero, no result pending
module contact_effective_mass_unit #(
   parameter int FRAC_BITS  = cem_pkg::FRAC_BITS_DEF,
   parameter int WORD_WIDTH = cem_pkg::WORD_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // param_index, param_value, arm_a_x/y/z, arm_b_x/y/z, dir_x/y/z, zero pad
   input  logic [cem_pkg::REQ_TDATA_W-1:0] req_tdata,
   // mode
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // eff_mass_k
   output logic [31:0]                     rsp_tdata,
   // saturated
   output logic                            rsp_tuser
);

   cem_pkg::cmd_type cmd;
   cem_pkg::sts_type sts;

   cem_ctrl #(
      .WORD_WIDTH(WORD_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   cem_dpath #(
      .FRAC_BITS (FRAC_BITS),
      .WORD_WIDTH(WORD_WIDTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: tb/sv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [255:0] wide_type;

   typedef struct {
      logic        mode;
      logic [4:0]  pidx;
      logic [31:0] pval;
      logic [31:0] vec[9];   // arm a xyz, arm b xyz, axis xyz
   } contact_item_type;

   typedef struct {
      logic [31:0] k;
      logic        sat;
   } k_result_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [cem_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                            req_tuser = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [31:0]                     rsp_tdata;
   logic                            rsp_tuser;

   logic signed [31:0] body_store[cem_pkg::NPARAM];
   k_result_type       k_expected[$];
   int                 fails = 0;
   int                 send_idle_pct = 0;
   int                 recv_stall_pct = 0;
   int                 hold_req = 0;
   int                 hold_seen = 0;
   int                 hold_cycles = 0;

   contact_effective_mass_unit DUT (.*);

   initial forever #5 clock = ~clock;

   initial begin
      #10ms;
      $display("Mismatches found");
      $finish;
   end

   function automatic wide_type angular_term(int base, wide_type r[3], wide_type n[3]);
      wide_type c[3], t[3], u[3];
      c[0] = r[1] * n[2] - r[2] * n[1];
      c[1] = r[2] * n[0] - r[0] * n[2];
      c[2] = r[0] * n[1] - r[1] * n[0];
      for (int row = 0; row < 3; row++) begin
         t[row] = '0;
         for (int col = 0; col < 3; col++)
            t[row] += c[col] * wide_type'(body_store[base + col * 3 + row]);
      end
      u[0] = t[1] * r[2] - t[2] * r[1];
      u[1] = t[2] * r[0] - t[0] * r[2];
      u[2] = t[0] * r[1] - t[1] * r[0];
      return u[0] * n[0] + u[1] * n[1] + u[2] * n[2];
   endfunction

   function automatic k_result_type predict_k(contact_item_type it);
      wide_type ra[3], rb[3], n[3], k;
      k_result_type res;
      for (int i = 0; i < 3; i++) begin
         ra[i] = wide_type'($signed(it.vec[i]));
         rb[i] = wide_type'($signed(it.vec[3 + i]));
         n[i]  = wide_type'($signed(it.vec[6 + i]));
      end
      k = (wide_type'(body_store[0]) + wide_type'(body_store[10])) <<< 64;
      k = k + angular_term(1, ra, n) + angular_term(11, rb, n) + (wide_type'(1) <<< 63);
      k = k >>> 64;
      res.sat = 1'b1;
      if (k > wide_type'(32'sh7fffffff)) res.k = 32'h7fffffff;
      else if (k < -wide_type'(64'sh80000000)) res.k = 32'h80000000;
      else begin
         res.k = k[31:0];
         res.sat = 1'b0;
      end
      return res;
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
         2: case ($urandom_range(4))
               0: return 32'h80000000;
               1: return 32'h7fffffff;
               2: return 32'h0;
               3: return 32'h1;
               default: return 32'hffffffff;
            endcase
         default: return (32'($urandom_range(0, 8)) - 32'd4) << 16;
      endcase
   endfunction

   task automatic send_item(contact_item_type it);
      logic [cem_pkg::REQ_TDATA_W-1:0] data;
      data = '0;
      data[cem_pkg::OFS_PIDX +: 5]  = it.pidx;
      data[cem_pkg::OFS_PVAL +: 32] = it.pval;
      for (int i = 0; i < 9; i++) data[cem_pkg::OFS_ARM_A + 32 * i +: 32] = it.vec[i];
      if (req_tvalid == 1'b0 || $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.mode;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (it.mode == cem_pkg::MODE_WRITE) begin
         if (it.pidx < cem_pkg::NPARAM) body_store[it.pidx] = it.pval;
      end else
         k_expected.push_back(predict_k(it));
   endtask

   task automatic send_write(logic [4:0] idx, logic [31:0] val);
      contact_item_type it;
      it.mode = cem_pkg::MODE_WRITE;
      it.pidx = idx;
      it.pval = val;
      foreach (it.vec[i]) it.vec[i] = $urandom;
      send_item(it);
   endtask

   task automatic send_eval(logic [31:0] v[9]);
      contact_item_type it;
      it.mode = cem_pkg::MODE_EVAL;
      it.pidx = 5'($urandom);
      it.pval = $urandom;
      it.vec  = v;
      send_item(it);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (k_expected.size() != 0) @(posedge clock);
      repeat (160) @(posedge clock);
   endtask

   task automatic test_directed();
      logic [31:0] v[9];
      foreach (v[i]) v[i] = 32'h0001_0000;
      send_eval(v);                                  // empty store gives zero
      send_write(cem_pkg::MASS_A_IDX, 32'h7fffffff);
      send_write(cem_pkg::MASS_B_IDX, 32'h7fffffff);
      send_eval(v);                                  // positive clamp
      send_write(cem_pkg::MASS_A_IDX, 32'h80000000);
      send_write(cem_pkg::MASS_B_IDX, 32'h80000000);
      send_eval(v);                                  // negative clamp
      send_write(5'd20, 32'h1234_5678);              // ignored indices
      send_write(5'd31, 32'hffff_ffff);
      send_eval(v);
      send_write(cem_pkg::MASS_A_IDX, 32'h0000_8000);
      send_write(cem_pkg::MASS_B_IDX, 32'h0);
      for (int i = 0; i < 9; i++)
         send_write(cem_pkg::INER_A_IDX + 5'(i), (i % 4 == 0) ? 32'h1_0000 : 32'h0);
      send_write(cem_pkg::INER_B_IDX + 5'd4, 32'h7fffffff);
      v = '{32'h1_0000, 0, 0, 32'h8000, 32'h8000, 0, 0, 32'h1_0000, 0};
      send_eval(v);                                  // rounding with a half
      foreach (v[i]) v[i] = (i % 2) ? 32'h80000000 : 32'h7fffffff;
      send_eval(v);                                  // extreme arms and axis
      drain();
   endtask

   task automatic test_random(int count, int idle, int stall);
      logic [31:0] v[9];
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      repeat (count) begin
         if ($urandom_range(99) < 40) begin
            if ($urandom_range(9) == 0) send_write(5'($urandom_range(20, 31)), $urandom);
            else send_write(5'($urandom_range(0, cem_pkg::NPARAM - 1)), rand_word());
         end else begin
            foreach (v[i]) v[i] = rand_word();
            send_eval(v);
         end
      end
      drain();
   endtask

   task automatic test_backpressure();
      logic [31:0] v[9];
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_req       = hold_req + 1;
      repeat (6) begin
         foreach (v[i]) v[i] = rand_word();
         send_eval(v);
      end
      drain();
   endtask

   always @(posedge clock) begin
      if (hold_seen != hold_req) begin
         hold_seen   <= hold_req;
         hold_cycles <= 800;
         rsp_tready  <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 1'b0;
      end else
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      k_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (k_expected.size() == 0) begin
            $error("unexpected item: eff_mass_k %h saturated %b", rsp_tdata, rsp_tuser);
            fails++;
         end else begin
            e = k_expected.pop_front();
            if (rsp_tdata !== e.k) begin
               $error("eff_mass_k expected %h actual %h", e.k, rsp_tdata);
               fails++;
            end
            if (rsp_tuser !== e.sat) begin
               $error("saturated expected %b actual %b", e.sat, rsp_tuser);
               fails++;
            end
         end
      end
   end

   initial begin
      foreach (body_store[i]) body_store[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(150, 0, 0);
      test_random(130, 77, 0);
      test_random(130, 0, 77);
      test_random(130, 31, 31);
      test_backpressure();
      if (fails == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
